### src/tvfs_pkg.sv
`default_nettype none
package tvfs_pkg;
  localparam int unsigned GridNxDefault = 16;
  localparam int unsigned GridNyDefault = 16;
  localparam int unsigned GridNzDefault = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracW = 16;

  localparam logic [CfgIdxW-1:0] RegOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScaleX  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScaleY  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScaleZ  = 3'd5;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [DataW-1:0] ScaleReset = 32'h0001_0000;

  // a + floor((b - a) * f / 65536), a 33x17 multiply
  function automatic logic signed [DataW-1:0] lerp(input logic signed [DataW-1:0] a,
                                                  input logic signed [DataW-1:0] b,
                                                  input logic [FracW-1:0] f);
    logic signed [DataW:0] diff;
    logic signed [DataW+FracW+1:0] prod;
    logic signed [DataW+1:0] q;
    logic signed [DataW+1:0] sum;
    diff = 33'(signed'(b)) - 33'(signed'(a));
    prod = 50'(diff) * 50'(signed'({1'b0, f}));
    q    = 34'(prod >>> FracW);
    sum  = 34'(signed'(a)) + q;
    return sum[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

### src/tvfs_axis_map.sv
`default_nettype none
// Maps one coordinate to a cell and fraction; one register stage after the multiply.
module tvfs_axis_map #(
  parameter int unsigned N = tvfs_pkg::GridNxDefault,
  parameter int unsigned CellW = $clog2(N)
) (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic [tvfs_pkg::DataW-1:0]  pos_i,
  input  wire logic [tvfs_pkg::DataW-1:0]  org_i,
  input  wire logic [tvfs_pkg::DataW-1:0]  scl_i,
  output logic                             hit_o,
  output logic [CellW-1:0]                 cell_o,
  output logic [tvfs_pkg::FracW-1:0]       frac_o
);
  logic signed [tvfs_pkg::DataW:0] diff;
  logic neg;
  logic [tvfs_pkg::DataW-1:0] mag;
  logic [2*tvfs_pkg::DataW-1:0] prod_d, prod_q;
  logic neg_q;
  logic [tvfs_pkg::DataW-1:0] c;

  assign diff = 33'(signed'(pos_i)) - 33'(signed'(org_i));
  assign neg  = diff[tvfs_pkg::DataW];
  assign mag  = neg ? 32'(-diff) : diff[tvfs_pkg::DataW-1:0];
  assign prod_d = 64'(mag) * 64'(scl_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      neg_q  <= neg;
    end
  end

  assign c      = prod_q[2*tvfs_pkg::DataW-1:tvfs_pkg::DataW];
  assign hit_o  = !(neg_q && prod_q != '0) && (33'(c) + 33'd1 < 33'(N));
  assign cell_o = c[CellW-1:0];
  assign frac_o = prod_q[tvfs_pkg::DataW-1:tvfs_pkg::FracW];
endmodule
`default_nettype wire

### src/tvfs_grid_mem.sv
`default_nettype none
module tvfs_grid_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AddrW-1:0]              addr_i,
  input  wire logic [3*tvfs_pkg::DataW-1:0]  wdata_i,
  output logic [3*tvfs_pkg::DataW-1:0]       rdata_o
);
  logic [3*tvfs_pkg::DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### src/trilinear_vector_field_sampler.sv
`default_nettype none
// Write: busy stays low. Query: result strobe after the map state, eight corner
// reads from the registered memory, and the x, y and z lerp states;
// one item at a time, a new query only once busy has dropped. A miss strobes
// from the map state and the next item can then be taken.
// Reset clears control and configuration; grid content is undefined until written.
// The receiver cannot stall: results appear for one cycle with valid_o.
module trilinear_vector_field_sampler #(
  parameter int unsigned GRID_NX = tvfs_pkg::GridNxDefault,
  parameter int unsigned GRID_NY = tvfs_pkg::GridNyDefault,
  parameter int unsigned GRID_NZ = tvfs_pkg::GridNzDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                op_i,
  input  wire logic [3:0]                          cell_i_i,
  input  wire logic [3:0]                          cell_j_i,
  input  wire logic [3:0]                          cell_k_i,
  input  wire logic signed [tvfs_pkg::DataW-1:0]   vec_x_i,
  input  wire logic signed [tvfs_pkg::DataW-1:0]   vec_y_i,
  input  wire logic signed [tvfs_pkg::DataW-1:0]   vec_z_i,
  input  wire logic signed [tvfs_pkg::DataW-1:0]   pos_x_i,
  input  wire logic signed [tvfs_pkg::DataW-1:0]   pos_y_i,
  input  wire logic signed [tvfs_pkg::DataW-1:0]   pos_z_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [tvfs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [tvfs_pkg::DataW-1:0]          cfg_data_i,
  output logic                                     valid_o,
  output logic                                     inside_res_o,
  output logic signed [tvfs_pkg::DataW-1:0]        out_x_o,
  output logic signed [tvfs_pkg::DataW-1:0]        out_y_o,
  output logic signed [tvfs_pkg::DataW-1:0]        out_z_o
);
  localparam int unsigned Dw = tvfs_pkg::DataW;
  localparam int unsigned Fw = tvfs_pkg::FracW;
  localparam int unsigned XW = $clog2(GRID_NX);
  localparam int unsigned YW = $clog2(GRID_NY);
  localparam int unsigned ZW = $clog2(GRID_NZ);
  localparam int unsigned Depth = GRID_NX * GRID_NY * GRID_NZ;
  localparam int unsigned AW = $clog2(Depth);

  typedef enum logic [2:0] {
    StIdle, StMap, StRead, StLerpX, StLerpY, StLerpZ
  } state_e;

  state_e state_q;
  logic [3:0] cnt_q;
  logic [Dw-1:0] org_x_q, org_y_q, org_z_q, scl_x_q, scl_y_q, scl_z_q;
  logic [XW-1:0] ci_q; logic [YW-1:0] cj_q; logic [ZW-1:0] ck_q;
  logic [Fw-1:0] fx_q, fy_q, fz_q;
  logic [3*Dw-1:0] corner_q [8];
  logic [3*Dw-1:0] ly_q [4];
  logic [3*Dw-1:0] lz_q [2];

  logic accept;
  assign accept      = start && !busy;
  assign busy        = state_q != StIdle;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0; org_y_q <= '0; org_z_q <= '0;
      scl_x_q <= tvfs_pkg::ScaleReset;
      scl_y_q <= tvfs_pkg::ScaleReset;
      scl_z_q <= tvfs_pkg::ScaleReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tvfs_pkg::RegOriginX: org_x_q <= cfg_data_i;
        tvfs_pkg::RegOriginY: org_y_q <= cfg_data_i;
        tvfs_pkg::RegOriginZ: org_z_q <= cfg_data_i;
        tvfs_pkg::RegScaleX:  scl_x_q <= cfg_data_i;
        tvfs_pkg::RegScaleY:  scl_y_q <= cfg_data_i;
        tvfs_pkg::RegScaleZ:  scl_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic hx, hy, hz;
  logic [XW-1:0] mcx; logic [YW-1:0] mcy; logic [ZW-1:0] mcz;
  logic [Fw-1:0] mfx, mfy, mfz;
  logic map_load;
  assign map_load = accept && op_i == tvfs_pkg::OpQuery;

  tvfs_axis_map #(.N(GRID_NX), .CellW(XW)) u_map_x (
    .clk_i, .load_i(map_load), .pos_i(pos_x_i), .org_i(org_x_q), .scl_i(scl_x_q),
    .hit_o(hx), .cell_o(mcx), .frac_o(mfx));
  tvfs_axis_map #(.N(GRID_NY), .CellW(YW)) u_map_y (
    .clk_i, .load_i(map_load), .pos_i(pos_y_i), .org_i(org_y_q), .scl_i(scl_y_q),
    .hit_o(hy), .cell_o(mcy), .frac_o(mfy));
  tvfs_axis_map #(.N(GRID_NZ), .CellW(ZW)) u_map_z (
    .clk_i, .load_i(map_load), .pos_i(pos_z_i), .org_i(org_z_q), .scl_i(scl_z_q),
    .hit_o(hz), .cell_o(mcz), .frac_o(mfz));

  logic wr_ok, mem_we;
  logic [AW-1:0] wr_addr, rd_addr, mem_addr;
  logic [XW-1:0] ri; logic [YW-1:0] rj; logic [ZW-1:0] rk;
  logic [3*Dw-1:0] rdata;

  assign wr_ok = 32'(cell_i_i) < GRID_NX && 32'(cell_j_i) < GRID_NY
              && 32'(cell_k_i) < GRID_NZ;
  assign wr_addr = AW'(32'(cell_i_i) + GRID_NX * (32'(cell_j_i) + GRID_NY * 32'(cell_k_i)));
  assign ri = ci_q + XW'(cnt_q[0]);
  assign rj = cj_q + YW'(cnt_q[1]);
  assign rk = ck_q + ZW'(cnt_q[2]);
  assign rd_addr = AW'(32'(ri) + GRID_NX * (32'(rj) + GRID_NY * 32'(rk)));
  assign mem_we   = accept && op_i == tvfs_pkg::OpWrite && wr_ok;
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  tvfs_grid_mem #(.Depth(Depth), .AddrW(AW)) u_mem (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr),
    .wdata_i({vec_z_i, vec_y_i, vec_x_i}), .rdata_o(rdata));

  function automatic logic [3*Dw-1:0] lerp3(input logic [3*Dw-1:0] a,
                                            input logic [3*Dw-1:0] b,
                                            input logic [Fw-1:0] f);
    return {tvfs_pkg::lerp(a[3*Dw-1:2*Dw], b[3*Dw-1:2*Dw], f),
            tvfs_pkg::lerp(a[2*Dw-1:Dw], b[2*Dw-1:Dw], f),
            tvfs_pkg::lerp(a[Dw-1:0], b[Dw-1:0], f)};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (map_load) state_q <= StMap;
        end
        StMap: begin
          ci_q <= mcx; cj_q <= mcy; ck_q <= mcz;
          fx_q <= mfx; fy_q <= mfy; fz_q <= mfz;
          cnt_q <= '0;
          if (hx && hy && hz) begin
            state_q <= StRead;
          end else begin
            valid_o      <= 1'b1;
            inside_res_o <= 1'b0;
            out_x_o <= '0; out_y_o <= '0; out_z_o <= '0;
            state_q <= StIdle;
          end
        end
        StRead: begin
          if (cnt_q != 4'd0) corner_q[3'(cnt_q - 4'd1)] <= rdata;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd8) state_q <= StLerpX;
        end
        StLerpX: begin
          for (int n = 0; n < 4; n++) begin
            ly_q[n] <= lerp3(corner_q[2*n], corner_q[2*n+1], fx_q);
          end
          state_q <= StLerpY;
        end
        StLerpY: begin
          lz_q[0] <= lerp3(ly_q[0], ly_q[1], fy_q);
          lz_q[1] <= lerp3(ly_q[2], ly_q[3], fy_q);
          state_q <= StLerpZ;
        end
        StLerpZ: begin
          {out_z_o, out_y_o, out_x_o} <= lerp3(lz_q[0], lz_q[1], fz_q);
          inside_res_o <= 1'b1;
          valid_o      <= 1'b1;
          state_q      <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/tvfs_checker.sv
`default_nettype none
module tvfs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic op_i,
  input wire logic valid_o,
  input wire logic inside_res_o,
  input wire logic [31:0] out_x_o
);
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !inside_res_o |-> out_x_o == '0) else $error("miss not zero");
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !op_i |=> !busy) else $error("write held busy");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i |=> busy) else $error("query not taken");
  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("double result");
endmodule

bind trilinear_vector_field_sampler tvfs_checker u_tvfs_checker (
  .clk_i, .rst_ni, .start, .busy, .op_i, .valid_o, .inside_res_o, .out_x_o);
`default_nettype wire

### tb/sv/field_sample_checker.sv
module field_sample_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        op_i,
  input  logic [3:0]  cell_i_i,
  input  logic [3:0]  cell_j_i,
  input  logic [3:0]  cell_k_i,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        valid_i,
  input  logic        inside_res_i,
  input  logic [31:0] out_x_i,
  input  logic [31:0] out_y_i,
  input  logic [31:0] out_z_i,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int Nx = tvfs_pkg::GridNxDefault;
  localparam int Ny = tvfs_pkg::GridNyDefault;
  localparam int Nz = tvfs_pkg::GridNzDefault;
  localparam int Cells = Nx * Ny * Nz;

  typedef struct {
    logic        hit_flag;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } sample_t;

  logic [31:0] grid_vec[3][Cells];
  logic [31:0] org[3];
  logic [31:0] scl[3];
  sample_t     sample_q[$];

  function automatic bit axis_lookup(input logic [31:0] p, input logic [31:0] o,
                                     input logic [31:0] s, input int n,
                                     output int cell_idx, output logic [15:0] frac);
    longint      d;
    logic [32:0] mag;
    logic [64:0] prod;
    d = longint'($signed(p)) - longint'($signed(o));
    mag = (d < 0) ? 33'(-d) : 33'(d);
    prod = 65'(mag) * 65'(s);
    cell_idx = 0;
    frac = '0;
    if (d < 0 && prod != 0) return 0;
    if (prod[64:32] + 1 >= n) return 0;
    cell_idx = int'(prod[63:32]);
    frac = prod[31:16];
    return 1;
  endfunction

  function automatic longint blend(input longint a, input longint b, input logic [15:0] f);
    longint t;
    t = (b - a) * longint'(f);
    return a + (t >>> 16);
  endfunction

  function automatic longint corner(input int c, input int i, input int j, input int k);
    return longint'($signed(grid_vec[c][i + Nx * (j + Ny * k)]));
  endfunction

  function automatic logic [31:0] interp(input int c, input int i, input int j, input int k,
                                         input logic [15:0] fx, input logic [15:0] fy,
                                         input logic [15:0] fz);
    longint x00, x01, x10, x11, y0, y1, r;
    x00 = blend(corner(c, i, j, k), corner(c, i + 1, j, k), fx);
    x01 = blend(corner(c, i, j, k + 1), corner(c, i + 1, j, k + 1), fx);
    x10 = blend(corner(c, i, j + 1, k), corner(c, i + 1, j + 1, k), fx);
    x11 = blend(corner(c, i, j + 1, k + 1), corner(c, i + 1, j + 1, k + 1), fx);
    y0 = blend(x00, x10, fy);
    y1 = blend(x01, x11, fy);
    r = blend(y0, y1, fz);
    return r[31:0];
  endfunction

  function automatic sample_t predict_sample(input logic [31:0] px, input logic [31:0] py,
                                             input logic [31:0] pz);
    sample_t     s;
    int          ci, cj, ck;
    logic [15:0] fx, fy, fz;
    bit          hit;
    s = '{hit_flag: 1'b0, vx: '0, vy: '0, vz: '0};
    hit = axis_lookup(px, org[0], scl[0], Nx, ci, fx);
    if (hit) hit = axis_lookup(py, org[1], scl[1], Ny, cj, fy);
    if (hit) hit = axis_lookup(pz, org[2], scl[2], Nz, ck, fz);
    if (hit) begin
      s.hit_flag = 1'b1;
      s.vx = interp(0, ci, cj, ck, fx, fy, fz);
      s.vy = interp(1, ci, cj, ck, fx, fy, fz);
      s.vz = interp(2, ci, cj, ck, fx, fy, fz);
    end
    return s;
  endfunction

  assign pending_o = sample_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t e;
    int      idx;
    if (!rst_ni) begin
      fail_count_o <= 0;
      sample_q.delete();
      for (int a = 0; a < 3; a++) begin
        org[a] = '0;
        scl[a] = tvfs_pkg::ScaleReset;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          tvfs_pkg::RegOriginX: org[0] = cfg_data_i;
          tvfs_pkg::RegOriginY: org[1] = cfg_data_i;
          tvfs_pkg::RegOriginZ: org[2] = cfg_data_i;
          tvfs_pkg::RegScaleX:  scl[0] = cfg_data_i;
          tvfs_pkg::RegScaleY:  scl[1] = cfg_data_i;
          tvfs_pkg::RegScaleZ:  scl[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (valid_i) begin
        if (sample_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = sample_q.pop_front();
          if (inside_res_i !== e.hit_flag || out_x_i !== e.vx || out_y_i !== e.vy ||
              out_z_i !== e.vz) begin
            fail_count_o <= fail_count_o + 1;
            if (inside_res_i !== e.hit_flag)
              $error("inside_res: expected %0d, got %0d", e.hit_flag, inside_res_i);
            if (out_x_i !== e.vx)
              $error("out_x: expected %h, got %h", e.vx, out_x_i);
            if (out_y_i !== e.vy)
              $error("out_y: expected %h, got %h", e.vy, out_y_i);
            if (out_z_i !== e.vz)
              $error("out_z: expected %h, got %h", e.vz, out_z_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (op_i == tvfs_pkg::OpWrite) begin
          if (cell_i_i < Nx && cell_j_i < Ny && cell_k_i < Nz) begin
            idx = cell_i_i + Nx * (cell_j_i + Ny * cell_k_i);
            grid_vec[0][idx] = vec_x_i;
            grid_vec[1][idx] = vec_y_i;
            grid_vec[2][idx] = vec_z_i;
          end
        end else begin
          sample_q.push_back(predict_sample(pos_x_i, pos_y_i, pos_z_i));
        end
      end
    end
  end
endmodule

### tb/sv/tb.sv
module tb;
  localparam int StallLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = tvfs_pkg::OpWrite;
  logic [3:0]  cell_i_i = '0, cell_j_i = '0, cell_k_i = '0;
  logic [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = tvfs_pkg::RegOriginX;
  logic [31:0] cfg_data_i = '0;
  logic        valid_o, inside_res_o;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  int          fail_count, pending;
  int          idle_pct = 0;
  int          item_count = 0, result_count = 0, reg_writes = 0, settings = 0;
  int          stall_cycles = 0;
  logic [31:0] cur_org[3];
  logic [31:0] cur_scl[3];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  trilinear_vector_field_sampler uut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .cell_i_i, .cell_j_i, .cell_k_i,
    .vec_x_i, .vec_y_i, .vec_z_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .valid_o, .inside_res_o, .out_x_o, .out_y_o, .out_z_o
  );

  field_sample_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i, .cell_i_i, .cell_j_i,
    .cell_k_i, .vec_x_i, .vec_y_i, .vec_z_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .valid_i(valid_o), .inside_res_i(inside_res_o), .out_x_i(out_x_o),
    .out_y_i(out_y_o), .out_z_i(out_z_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (valid_o) result_count++;
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || valid_o || !rst_ni)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [3:0] ci, input logic [3:0] cj,
                           input logic [3:0] ck, input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] vz, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    cell_i_i <= ci;
    cell_j_i <= cj;
    cell_k_i <= ck;
    vec_x_i <= vx;
    vec_y_i <= vy;
    vec_z_i <= vz;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    item_count++;
  endtask

  task automatic write_vec(input int i, input int j, input int k, input logic [31:0] vx,
                           input logic [31:0] vy, input logic [31:0] vz);
    send_item(tvfs_pkg::OpWrite, 4'(i), 4'(j), 4'(k), vx, vy, vz, $urandom, $urandom,
              $urandom);
  endtask

  task automatic query(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
    send_item(tvfs_pkg::OpQuery, 4'($urandom), 4'($urandom), 4'($urandom), $urandom,
              $urandom, $urandom, px, py, pz);
  endtask

  // drain results, then let a trailing query finish
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
    if (idx <= tvfs_pkg::RegOriginZ) cur_org[idx] = val;
    else cur_scl[idx - tvfs_pkg::RegScaleX] = val;
  endtask

  task automatic apply_setting(input logic [31:0] o[3], input logic [31:0] s[3]);
    drain();
    set_reg(tvfs_pkg::RegOriginX, o[0]);
    set_reg(tvfs_pkg::RegOriginY, o[1]);
    set_reg(tvfs_pkg::RegOriginZ, o[2]);
    set_reg(tvfs_pkg::RegScaleX, s[0]);
    set_reg(tvfs_pkg::RegScaleY, s[1]);
    set_reg(tvfs_pkg::RegScaleZ, s[2]);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // position that maps to grid coordinate u (Q16.16) on one axis
  function automatic logic [31:0] aim(input int a, input longint u);
    longint p;
    if (cur_scl[a] == 0) return cur_org[a] + 32'($urandom_range(0, 4));
    p = longint'($signed(cur_org[a])) + (u * 65536) / longint'(cur_scl[a]);
    return p[31:0];
  endfunction

  function automatic logic [31:0] rand_axis(input int a);
    case ($urandom_range(9))
      0: return $urandom;
      1: return cur_org[a] - 32'($urandom_range(1, 3));
      2: return aim(a, 64'(15 * 65536) + $urandom_range(0, 3));
      3: return aim(a, 64'(15 * 65536) - $urandom_range(1, 3));
      default: return aim(a, $urandom_range(0, 15 * 65536 - 1));
    endcase
  endfunction

  task automatic random_run(input int n);
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(3) == 0)
        write_vec($urandom_range(15), $urandom_range(15), $urandom_range(15),
                  $urandom, $urandom, $urandom);
      else
        query(rand_axis(0), rand_axis(1), rand_axis(2));
    end
  endtask

  initial begin
    logic [31:0] o[3];
    logic [31:0] s[3];
    for (int a = 0; a < 3; a++) begin
      cur_org[a] = '0;
      cur_scl[a] = tvfs_pkg::ScaleReset;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < 16; k++)
      for (int j = 0; j < 16; j++)
        for (int i = 0; i < 16; i++)
          write_vec(i, j, k, $urandom, $urandom, $urandom);

    write_vec(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    write_vec(1, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    write_vec(15, 15, 15, 32'hffff_ffff, 32'h0, 32'h8000_0000);
    query(32'h0, 32'h0, 32'h0);
    query(32'h0000_8000, 32'h0000_ffff, 32'h0000_0001);
    query(32'hffff_ffff, 32'h0, 32'h0);
    query(32'h000e_ffff, 32'h000e_ffff, 32'h000e_ffff);
    query(32'h000f_0000, 32'h0001_0000, 32'h0001_0000);
    query(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    query(32'h7fff_ffff, 32'h0, 32'h8000_0000);

    o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    s = '{32'h0, 32'h0, 32'h0};
    apply_setting(o, s);
    query(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678);
    query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    o = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    s = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    apply_setting(o, s);
    query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    query(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    query(32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 75;
        2: idle_pct = 21;
        default: idle_pct = 0;
      endcase
      for (int a = 0; a < 3; a++) begin
        case (ph)
          0: begin o[a] = '0; s[a] = tvfs_pkg::ScaleReset; end
          1: begin o[a] = $urandom; s[a] = $urandom_range(32'h4000, 32'h40000); end
          2: begin o[a] = 32'h8000_0000; s[a] = $urandom_range(32'h1000, 32'h10000); end
          3: begin o[a] = $urandom; s[a] = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff; end
          4: begin o[a] = 32'h7fff_ffff - 32'($urandom_range(0, 32'h1000));
                   s[a] = $urandom; end
          default: begin o[a] = $urandom; s[a] = $urandom_range(32'h100, 32'h200000); end
        endcase
      end
      apply_setting(o, s);
      random_run(230);
    end

    drain();
    $display("tb: %0d items, %0d results, %0d register writes over %0d settings",
             item_count, result_count, reg_writes, settings);
    $display("tb: grid fill, corner and edge queries, extreme origins and scales");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### sim.f
src/tvfs_pkg.sv
src/tvfs_axis_map.sv
src/tvfs_grid_mem.sv
src/trilinear_vector_field_sampler.sv
src/tvfs_checker.sv
tb/sv/field_sample_checker.sv
tb/sv/tb.sv
